### design/pmg_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes and sideband types of the gravity force pipeline.
package pmg_pkg;

    localparam int PW    = 32;   // position coordinate
    localparam int DW    = 33;   // per-axis separation
    localparam int SW    = 66;   // squared distance in cm^2
    localparam int MDW   = 24;   // minimum distance register
    localparam int TW    = 31;   // minimum distance in cm
    localparam int LW    = 62;   // squared minimum distance
    localparam int GPW   = 48;   // G*M, Q24.24
    localparam int KSW   = 22;   // width of the unit scale factor
    localparam int KW    = GPW + KSW;
    localparam int MASSW = 32;
    localparam int GW    = KW + MASSW;
    localparam int RW    = 49;   // distance root, cm as Q.16
    localparam int RMW   = RW + 3;
    localparam int RAD_SHIFT = 32;
    localparam int NW    = GW + DW;
    localparam int DNW   = SW + RW;
    localparam int FW    = 48;
    localparam int CIW   = 3;
    localparam int CDW   = 48;

    localparam int CW_GM  = 16;
    localparam int CW_DEN = 17;
    localparam int CW_NUM = 11;

    localparam int DIST_SCALE  = 100;
    // 10000 converts cm^2 to m^2 in the quotient, 256 aligns Q24.24 * Q.16 to Q.16.
    localparam int FORCE_SCALE = 2560000;

    localparam logic [FW-1:0] FORCE_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [FW-1:0] FORCE_NEG_MAG = 48'h8000_0000_0000;

    typedef enum logic [CIW-1:0] {
        CFG_SOURCE_X       = 3'd0,
        CFG_SOURCE_Y       = 3'd1,
        CFG_SOURCE_Z       = 3'd2,
        CFG_GRAV_PARAM     = 3'd3,
        CFG_MIN_DISTANCE_M = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic                  tc;
        logic [SW-1:0]         s;
        logic [2:0][DW-1:0]    mag;
        logic [2:0]            neg;
    } geo_t;

    typedef struct packed {
        geo_t          geo;
        logic [GW-1:0] gm;
    } root_side_t;

endpackage

### design/pmg_mul.sv
`timescale 1ns / 1ps
// Pipelined unsigned multiplier that consumes one slice of the second operand per stage.
module pmg_mul #(
    parameter int WA = 32,
    parameter int WB = 32,
    parameter int CW = 16,
    parameter int WT = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vld,
    input  logic [WA-1:0]    a,
    input  logic [WB-1:0]    b,
    input  logic [WT-1:0]    tag,
    output logic             p_vld,
    output logic [WA+WB-1:0] p,
    output logic [WT-1:0]    p_tag
);

    localparam int NC  = (WB + CW - 1) / CW;
    localparam int WBP = NC * CW;
    localparam int WP  = WA + WB;

    logic [WA-1:0]  a_reg   [NC];
    logic [WBP-1:0] b_reg   [NC];
    logic [WP-1:0]  acc_reg [NC];
    logic [WT-1:0]  tag_reg [NC];
    logic [NC-1:0]  vld_reg;

    for (genvar j = 0; j < NC; j++)
    begin : g_stage
        logic [WA-1:0]    a_cur;
        logic [WBP-1:0]   b_cur;
        logic [WP-1:0]    acc_cur;
        logic [WT-1:0]    tag_cur;
        logic             vld_cur;
        logic [WA+CW-1:0] part;
        logic [WP-1:0]    acc_next;

        if (j == 0)
        begin : g_head
            assign a_cur   = a;
            assign b_cur   = WBP'(b);
            assign acc_cur = '0;
            assign tag_cur = tag;
            assign vld_cur = vld;
        end
        else
        begin : g_body
            assign a_cur   = a_reg[j-1];
            assign b_cur   = b_reg[j-1];
            assign acc_cur = acc_reg[j-1];
            assign tag_cur = tag_reg[j-1];
            assign vld_cur = vld_reg[j-1];
        end

        assign part     = a_cur * b_cur[j*CW +: CW];
        assign acc_next = acc_cur + (WP'(part) << (j * CW));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            a_reg[j]   <= a_cur;
            b_reg[j]   <= b_cur;
            acc_reg[j] <= acc_next;
            tag_reg[j] <= tag_cur;
        end
    end

    assign p_vld = vld_reg[NC-1];
    assign p     = acc_reg[NC-1];
    assign p_tag = tag_reg[NC-1];

endmodule

### design/pmg_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with quotient overflow detection.
module pmg_div #(
    parameter int WN = 64,
    parameter int WD = 32,
    parameter int WQ = 32,
    parameter int WT = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          vld,
    input  logic [WN-1:0] num,
    input  logic [WD-1:0] den,
    input  logic [WT-1:0] tag,
    output logic          q_vld,
    output logic [WQ-1:0] q,
    output logic          q_ovf,
    output logic [WT-1:0] q_tag
);

    localparam int WM = (WN > WD) ? WN : WD;

    logic [WN-1:0] hi;
    logic          ovf_next;

    logic [WD-1:0] rem0_reg;
    logic [WQ-1:0] lq0_reg;
    logic [WD-1:0] den0_reg;
    logic          ovf0_reg;
    logic [WT-1:0] tag0_reg;
    logic          vld0_reg;

    logic [WD-1:0] rem_reg [WQ];
    logic [WQ-1:0] lq_reg  [WQ];
    logic [WD-1:0] den_reg [WQ];
    logic [WQ-1:0] ovf_reg;
    logic [WT-1:0] tag_reg [WQ];
    logic [WQ-1:0] vld_reg;

    // The quotient fits WQ bits only when the numerator's upper part is below the divisor.
    assign hi       = num >> WQ;
    assign ovf_next = WM'(hi) >= WM'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rem0_reg <= WD'(hi);
        lq0_reg  <= num[WQ-1:0];
        den0_reg <= den;
        ovf0_reg <= ovf_next;
        tag0_reg <= tag;
    end

    for (genvar k = 0; k < WQ; k++)
    begin : g_step
        logic [WD-1:0] rem_cur;
        logic [WQ-1:0] lq_cur;
        logic [WD-1:0] den_cur;
        logic          ovf_cur;
        logic [WT-1:0] tag_cur;
        logic          vld_cur;
        logic [WD:0]   sh;
        logic [WD:0]   diff;
        logic          ge;

        if (k == 0)
        begin : g_head
            assign rem_cur = rem0_reg;
            assign lq_cur  = lq0_reg;
            assign den_cur = den0_reg;
            assign ovf_cur = ovf0_reg;
            assign tag_cur = tag0_reg;
            assign vld_cur = vld0_reg;
        end
        else
        begin : g_body
            assign rem_cur = rem_reg[k-1];
            assign lq_cur  = lq_reg[k-1];
            assign den_cur = den_reg[k-1];
            assign ovf_cur = ovf_reg[k-1];
            assign tag_cur = tag_reg[k-1];
            assign vld_cur = vld_reg[k-1];
        end

        // Numerator bits leave the top of lq while quotient bits enter at the bottom.
        assign sh   = {rem_cur, lq_cur[WQ-1]};
        assign diff = sh - {1'b0, den_cur};
        assign ge   = sh >= {1'b0, den_cur};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? diff[WD-1:0] : sh[WD-1:0];
            lq_reg[k]  <= {lq_cur[WQ-2:0], ge};
            den_reg[k] <= den_cur;
            ovf_reg[k] <= ovf_cur;
            tag_reg[k] <= tag_cur;
        end
    end

    assign q_vld = vld_reg[WQ-1];
    assign q     = lq_reg[WQ-1];
    assign q_ovf = ovf_reg[WQ-1];
    assign q_tag = tag_reg[WQ-1];

endmodule

### design/point_mass_gravity_force_top.sv
`timescale 1ns / 1ps
// A body accepted on start passes through 108 stages to its done strobe.
// Throughput: one body per cycle; every stage is a register, so busy never rises.
// Depth is set by the 49-stage distance square root and the 50-stage force dividers.
// Reset clears the source registers and all valid bits; cfg_ready is always high.
// Configuration writes are registered; gk_reg and thr_reg are registered from them, and lim_reg from thr_reg.
module point_mass_gravity_force_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [pmg_pkg::PW-1:0]    body_x,
    input  logic signed [pmg_pkg::PW-1:0]    body_y,
    input  logic signed [pmg_pkg::PW-1:0]    body_z,
    input  logic [pmg_pkg::MASSW-1:0]        body_mass,
    output logic                             done,
    output logic signed [pmg_pkg::FW-1:0]    force_x,
    output logic signed [pmg_pkg::FW-1:0]    force_y,
    output logic signed [pmg_pkg::FW-1:0]    force_z,
    output logic                             too_close,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pmg_pkg::CIW-1:0]          cfg_index,
    input  logic [pmg_pkg::CDW-1:0]          cfg_data
);

    localparam int PW    = pmg_pkg::PW;
    localparam int DW    = pmg_pkg::DW;
    localparam int SW    = pmg_pkg::SW;
    localparam int RW    = pmg_pkg::RW;
    localparam int RMW   = pmg_pkg::RMW;
    localparam int GW    = pmg_pkg::GW;
    localparam int KW    = pmg_pkg::KW;
    localparam int NW    = pmg_pkg::NW;
    localparam int DNW   = pmg_pkg::DNW;
    localparam int FW    = pmg_pkg::FW;
    localparam int MASSW = pmg_pkg::MASSW;

    // Configuration registers and values derived from them.
    logic signed [PW-1:0]       src_x_reg;
    logic signed [PW-1:0]       src_y_reg;
    logic signed [PW-1:0]       src_z_reg;
    logic [pmg_pkg::GPW-1:0]    gp_reg;
    logic [pmg_pkg::MDW-1:0]    min_dist_reg;
    logic [pmg_pkg::TW-1:0]     thr_reg;
    logic [pmg_pkg::LW-1:0]     lim_reg;
    logic [KW-1:0]              gk_reg;

    logic accept;

    logic signed [PW-1:0] src_v  [3];
    logic signed [PW-1:0] body_v [3];
    logic signed [DW-1:0] dv     [3];
    logic [2:0][DW-1:0]   mag_next;
    logic [2:0]           neg_next;

    logic                 v1_reg, v2_reg, v3_reg;
    logic [2:0][DW-1:0]   mag1_reg, mag2_reg, mag3_reg;
    logic [2:0]           neg1_reg, neg2_reg, neg3_reg;
    logic [MASSW-1:0]     mass1_reg, mass2_reg, mass3_reg;
    logic [SW-1:0]        sq2_reg [3];
    logic [SW-1:0]        s3_reg;

    pmg_pkg::geo_t        geo3;
    pmg_pkg::geo_t        gm_geo;
    logic [GW-1:0]        gm;
    logic                 gm_vld;
    pmg_pkg::root_side_t  rt_entry;

    logic [RMW-1:0]            rt_rem_reg  [RW];
    logic [RW-1:0]             rt_root_reg [RW];
    pmg_pkg::root_side_t       rt_side_reg [RW];
    logic [RW-1:0]             rt_vld_reg;
    pmg_pkg::root_side_t       rt_fin;

    logic [DNW-1:0] den;
    logic           den_vld;
    logic           den_tc;
    logic [NW-1:0]  num     [3];
    logic [2:0]     num_vld;
    logic [2:0]     num_neg;

    logic [RW-1:0]  qv      [3];
    logic [2:0]     q_vld;
    logic [2:0]     q_ovf;
    logic [1:0]     qx_tag;
    logic           qy_tag;
    logic           qz_tag;
    logic           q_all;

    logic                 done_reg;
    logic [FW-1:0]        fx_reg, fy_reg, fz_reg;
    logic                 tc_reg;

    function automatic logic [FW-1:0] sat_force(input logic [RW-1:0] q, input logic ovf,
                                                input logic neg);
        logic [FW-1:0] m;
        if (neg)
        begin
            m = (ovf || q > {1'b0, pmg_pkg::FORCE_NEG_MAG}) ? pmg_pkg::FORCE_NEG_MAG : q[FW-1:0];
            return FW'(~m + 1'b1);
        end
        else
        begin
            return (ovf || q[RW-1] || q[FW-1]) ? pmg_pkg::FORCE_POS_MAX : q[FW-1:0];
        end
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_x_reg    <= '0;
            src_y_reg    <= '0;
            src_z_reg    <= '0;
            gp_reg       <= '0;
            min_dist_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pmg_pkg::CFG_SOURCE_X:       src_x_reg    <= cfg_data[PW-1:0];
                pmg_pkg::CFG_SOURCE_Y:       src_y_reg    <= cfg_data[PW-1:0];
                pmg_pkg::CFG_SOURCE_Z:       src_z_reg    <= cfg_data[PW-1:0];
                pmg_pkg::CFG_GRAV_PARAM:     gp_reg       <= cfg_data[pmg_pkg::GPW-1:0];
                pmg_pkg::CFG_MIN_DISTANCE_M: min_dist_reg <= cfg_data[pmg_pkg::MDW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
            lim_reg <= '0;
            gk_reg  <= '0;
        end
        else
        begin
            thr_reg <= pmg_pkg::TW'(min_dist_reg) * pmg_pkg::TW'(pmg_pkg::DIST_SCALE);
            lim_reg <= thr_reg * thr_reg;
            gk_reg  <= KW'(gp_reg) * KW'(pmg_pkg::FORCE_SCALE);
        end
    end

    // Stage 1: separation and its magnitude per axis.
    assign src_v[0]  = src_x_reg;
    assign src_v[1]  = src_y_reg;
    assign src_v[2]  = src_z_reg;
    assign body_v[0] = body_x;
    assign body_v[1] = body_y;
    assign body_v[2] = body_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv[i]       = {src_v[i][PW-1], src_v[i]} - {body_v[i][PW-1], body_v[i]};
            neg_next[i] = dv[i][DW-1];
            mag_next[i] = dv[i][DW-1] ? DW'(-dv[i]) : DW'(dv[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag1_reg  <= mag_next;
        neg1_reg  <= neg_next;
        mass1_reg <= body_mass;
        for (int i = 0; i < 3; i++)
        begin
            sq2_reg[i] <= mag1_reg[i] * mag1_reg[i];
        end
        mag2_reg  <= mag1_reg;
        neg2_reg  <= neg1_reg;
        mass2_reg <= mass1_reg;
        s3_reg    <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
        mag3_reg  <= mag2_reg;
        neg3_reg  <= neg2_reg;
        mass3_reg <= mass2_reg;
    end

    // A coincident body counts as too close even with a zero minimum distance.
    assign geo3.tc  = (s3_reg == '0) || (s3_reg < SW'(lim_reg));
    assign geo3.s   = s3_reg;
    assign geo3.mag = mag3_reg;
    assign geo3.neg = neg3_reg;

    pmg_mul #(
        .WA (KW),
        .WB (MASSW),
        .CW (pmg_pkg::CW_GM),
        .WT ($bits(pmg_pkg::geo_t))
    ) u_gm_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .vld   (v3_reg),
        .a     (gk_reg),
        .b     (mass3_reg),
        .tag   (geo3),
        .p_vld (gm_vld),
        .p     (gm),
        .p_tag (gm_geo)
    );

    assign rt_entry.geo = gm_geo;
    assign rt_entry.gm  = gm;

    // Distance root: floor(sqrt(S * 2^32)), two radicand bits per stage.
    for (genvar k = 0; k < RW; k++)
    begin : g_root
        localparam int PI = RW - 1 - k;
        logic [RMW-1:0]      rem_cur;
        logic [RW-1:0]       root_cur;
        pmg_pkg::root_side_t side_cur;
        logic                vld_cur;
        logic [1:0]          pair;
        logic [RMW-1:0]      rem_sh;
        logic [RMW-1:0]      trial;
        logic                ge;

        if (k == 0)
        begin : g_head
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign side_cur = rt_entry;
            assign vld_cur  = gm_vld;
        end
        else
        begin : g_body
            assign rem_cur  = rt_rem_reg[k-1];
            assign root_cur = rt_root_reg[k-1];
            assign side_cur = rt_side_reg[k-1];
            assign vld_cur  = rt_vld_reg[k-1];
        end

        if (2 * PI >= pmg_pkg::RAD_SHIFT)
        begin : g_pair
            assign pair = side_cur.geo.s[2*PI-pmg_pkg::RAD_SHIFT +: 2];
        end
        else
        begin : g_zero
            assign pair = 2'b00;
        end

        assign rem_sh = {rem_cur[RMW-3:0], pair};
        assign trial  = RMW'({root_cur, 2'b01});
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_vld_reg[k] <= 1'b0;
            end
            else
            begin
                rt_vld_reg[k] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            rt_rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
            rt_root_reg[k] <= {root_cur[RW-2:0], ge};
            rt_side_reg[k] <= side_cur;
        end
    end

    assign rt_fin = rt_side_reg[RW-1];

    pmg_mul #(
        .WA (SW),
        .WB (RW),
        .CW (pmg_pkg::CW_DEN),
        .WT (1)
    ) u_den_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .vld   (rt_vld_reg[RW-1]),
        .a     (rt_fin.geo.s),
        .b     (rt_root_reg[RW-1]),
        .tag   (rt_fin.geo.tc),
        .p_vld (den_vld),
        .p     (den),
        .p_tag (den_tc)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_num
        pmg_mul #(
            .WA (GW),
            .WB (DW),
            .CW (pmg_pkg::CW_NUM),
            .WT (1)
        ) u_num_mul (
            .clk   (clk),
            .rst_n (rst_n),
            .vld   (rt_vld_reg[RW-1]),
            .a     (rt_fin.gm),
            .b     (rt_fin.geo.mag[i]),
            .tag   (rt_fin.geo.neg[i]),
            .p_vld (num_vld[i]),
            .p     (num[i]),
            .p_tag (num_neg[i])
        );
    end

    pmg_div #(
        .WN (NW),
        .WD (DNW),
        .WQ (RW),
        .WT (2)
    ) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .vld   (den_vld && num_vld[0]),
        .num   (num[0]),
        .den   (den),
        .tag   ({den_tc, num_neg[0]}),
        .q_vld (q_vld[0]),
        .q     (qv[0]),
        .q_ovf (q_ovf[0]),
        .q_tag (qx_tag)
    );

    pmg_div #(
        .WN (NW),
        .WD (DNW),
        .WQ (RW),
        .WT (1)
    ) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .vld   (den_vld && num_vld[1]),
        .num   (num[1]),
        .den   (den),
        .tag   (num_neg[1]),
        .q_vld (q_vld[1]),
        .q     (qv[1]),
        .q_ovf (q_ovf[1]),
        .q_tag (qy_tag)
    );

    pmg_div #(
        .WN (NW),
        .WD (DNW),
        .WQ (RW),
        .WT (1)
    ) u_div_z (
        .clk   (clk),
        .rst_n (rst_n),
        .vld   (den_vld && num_vld[2]),
        .num   (num[2]),
        .den   (den),
        .tag   (num_neg[2]),
        .q_vld (q_vld[2]),
        .q     (qv[2]),
        .q_ovf (q_ovf[2]),
        .q_tag (qz_tag)
    );

    assign q_all = &q_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= q_all;
        end
    end

    always_ff @(posedge clk)
    begin
        tc_reg <= qx_tag[1];
        fx_reg <= qx_tag[1] ? '0 : sat_force(qv[0], q_ovf[0], qx_tag[0]);
        fy_reg <= qx_tag[1] ? '0 : sat_force(qv[1], q_ovf[1], qy_tag);
        fz_reg <= qx_tag[1] ? '0 : sat_force(qv[2], q_ovf[2], qz_tag);
    end

    assign done      = done_reg;
    assign force_x   = fx_reg;
    assign force_y   = fy_reg;
    assign force_z   = fz_reg;
    assign too_close = tc_reg;

`ifndef SYNTH
    a_tc_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
        done && too_close |-> force_x == '0 && force_y == '0 && force_z == '0)
        else $error("too_close beat carries a nonzero force");

    a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        den_vld == num_vld[0] && num_vld[0] == num_vld[1] && num_vld[1] == num_vld[2])
        else $error("multiplier pipelines out of step");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        q_vld[0] == q_vld[1] && q_vld[1] == q_vld[2])
        else $error("divider pipelines out of step");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        q_all |=> done)
        else $error("finished quotient did not produce a result beat");
`endif

endmodule
